@@ src/smj_pkg.sv @@
// ----------------------------------------------------------------------------
// smj_pkg
// shared types, constants and helpers of the sorted table merge join
// ----------------------------------------------------------------------------
`default_nettype none

package smj_pkg;

    // table geometry
    localparam int SMJ_DEPTH      = 32;
    localparam int SMJ_VALUE_BITS = 64;
    localparam int SMJ_CNT_W      = $clog2(SMJ_DEPTH + 1);

    // request codes
    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_TRUNCATE = 2'd1,
        REQ_INTERSECT = 2'd2,
        REQ_SYMDIFF  = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef logic [SMJ_VALUE_BITS-1:0] t_value;
    typedef logic [SMJ_CNT_W-1:0]      t_count;

    // input transaction
    typedef struct packed {
        logic [1:0]         req_type;
        logic               table_sel;
        logic signed [31:0] key;
        logic [63:0]        row_value;
    } t_smj_in;

    // result transaction
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] row_key;
        logic [63:0]        value_a;
        logic [63:0]        value_b;
        logic               has_a;
        logic               has_b;
        logic               last;
    } t_smj_out;

    // per-cell operation
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_CMP,
        CELL_INSERT
    } t_cell_op;

    // control from the sequencer to one table
    typedef struct packed {
        t_cell_op op;
        logic     clear;
    } t_tbl_ctl;

    // status from one table to the sequencer
    typedef struct packed {
        logic signed [31:0] head_key;
        t_value             head_val;
        t_count             count;
        logic               dup;
        logic               full;
    } t_tbl_stat;

    // zero-extend a stored value to the 64-bit result field
    function automatic logic [63:0] smj_ext(input t_value v);
        logic [63:0] r;
        r = '0;
        r[SMJ_VALUE_BITS-1:0] = v;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/smj_cell.sv @@
// ----------------------------------------------------------------------------
// smj_cell
// one table slot: holds a key/value pair, compares, shifts and rotates
// ----------------------------------------------------------------------------
`default_nettype none

module smj_cell
    import smj_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_op           i_op,
    input  wire logic               i_valid,
    input  wire logic               i_ins_en,
    input  wire logic               i_prev_lt,
    input  wire logic signed [31:0] i_new_key,
    input  wire t_value             i_new_val,
    input  wire logic signed [31:0] i_prev_key,
    input  wire t_value             i_prev_val,
    input  wire logic signed [31:0] i_next_key,
    input  wire t_value             i_next_val,
    output logic signed [31:0]      o_key,
    output t_value                  o_val,
    output logic                    o_lt,
    output logic                    o_eq
);

    logic signed [31:0] r_key;
    t_value             r_val;
    logic               r_lt;
    logic               r_eq;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_ROTATE: begin
                r_key <= i_next_key;
                r_val <= i_next_val;
            end
            CELL_CMP: begin
                r_lt <= i_valid && (r_key < i_new_key);
                r_eq <= i_valid && (r_key == i_new_key);
            end
            CELL_INSERT: begin
                // cells below the insert point keep, the insert point loads,
                // cells above shift up by one
                if (i_ins_en && !r_lt) begin
                    if (i_prev_lt) begin
                        r_key <= i_new_key;
                        r_val <= i_new_val;
                    end else begin
                        r_key <= i_prev_key;
                        r_val <= i_prev_val;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key = r_key;
    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

`default_nettype wire

@@ src/smj_table.sv @@
// ----------------------------------------------------------------------------
// smj_table
// one sorted table as a chain of cells with its fill count
// ----------------------------------------------------------------------------
`default_nettype none

module smj_table
    import smj_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_tbl_ctl           i_ctl,
    input  wire logic signed [31:0] i_key,
    input  wire t_value             i_val,
    output t_tbl_stat               o_stat
);

    logic signed [31:0] w_key [SMJ_DEPTH];
    t_value             w_val [SMJ_DEPTH];
    logic [SMJ_DEPTH-1:0] w_lt;
    logic [SMJ_DEPTH-1:0] w_eq;
    t_count             r_count;
    logic               w_dup;
    logic               w_full;
    logic               w_ins_en;

    assign w_dup    = |w_eq;
    assign w_full   = (r_count == SMJ_CNT_W'(SMJ_DEPTH));
    assign w_ins_en = !w_dup && !w_full;

    for (genvar i = 0; i < SMJ_DEPTH; i++) begin : g_cell
        localparam int NXT = (i + 1) % SMJ_DEPTH;
        localparam int PRV = (i == 0) ? 0 : i - 1;
        logic w_valid;
        logic w_prev_lt;

        assign w_valid   = (SMJ_CNT_W'(i) < r_count);
        assign w_prev_lt = (i == 0) ? 1'b1 : w_lt[PRV];

        smj_cell u_cell (
            .i_clk      (i_clk),
            .i_op       (i_ctl.op),
            .i_valid    (w_valid),
            .i_ins_en   (w_ins_en),
            .i_prev_lt  (w_prev_lt),
            .i_new_key  (i_key),
            .i_new_val  (i_val),
            .i_prev_key (w_key[PRV]),
            .i_prev_val (w_val[PRV]),
            .i_next_key (w_key[NXT]),
            .i_next_val (w_val[NXT]),
            .o_key      (w_key[i]),
            .o_val      (w_val[i]),
            .o_lt       (w_lt[i]),
            .o_eq       (w_eq[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.op == CELL_INSERT && w_ins_en) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_stat.head_key = w_key[0];
    assign o_stat.head_val = w_val[0];
    assign o_stat.count    = r_count;
    assign o_stat.dup      = w_dup;
    assign o_stat.full     = w_full;

endmodule

`default_nettype wire

@@ src/sorted_table_merge_join.sv @@
// ----------------------------------------------------------------------------
// sorted_table_merge_join
// two sorted key/value tables with insert, truncate, intersection and
// symmetric difference queries
// ----------------------------------------------------------------------------
// usage
//   input channel i_in (valid/stall): one request transaction per item;
//   o_in_stall is high while a request is in progress
//   output channel o_out (valid/stall): result rows, last marks the final row
//   insert: result is registered after a compare step, then a shift step
//   truncate: takes effect at acceptance, no result, next request next cycle
//   queries: the two cell chains rotate so the merge heads sit in cell 0;
//   one walk step per cycle while the output is not stalled (count_a +
//   count_b steps at most), then the held row is flushed, then the chains
//   rotate on until each has turned SMJ_DEPTH times
//   one row is held back so that last can be known; a finished result waits
//   in the output register while a new request is accepted
//   stall on the output pauses the walk; no row is dropped or repeated
//   reset empties both tables; stored entries are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_merge_join
    import smj_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_smj_in  i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_smj_out      o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_WALK,
        S_FLUSH,
        S_RESTORE
    } t_state;

    // sequencer registers
    t_state             r_state, n_state;
    logic               r_sym, n_sym;
    logic               r_sel, n_sel;
    logic signed [31:0] r_key, n_key;
    t_value             r_val, n_val;
    t_count             r_ca, n_ca;
    t_count             r_cb, n_cb;
    logic               r_pend_valid, n_pend_valid;
    t_smj_out           r_pend, n_pend;
    logic               r_out_valid, n_out_valid;
    t_smj_out           r_out, n_out;

    // table interface
    t_tbl_ctl  w_ctl_a, w_ctl_b;
    t_tbl_stat w_st_a, w_st_b;
    t_tbl_stat w_st_sel;

    // merge step terms
    logic     w_out_free;
    logic     w_ha, w_hb;
    logic     w_take_a, w_take_b, w_both;
    logic     w_row_gen;
    logic     w_done;
    t_smj_out w_row;
    t_smj_out w_ins_res;
    t_smj_out w_empty;

    smj_table u_table_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_a),
        .i_key   (r_key),
        .i_val   (r_val),
        .o_stat  (w_st_a)
    );

    smj_table u_table_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_b),
        .i_key   (r_key),
        .i_val   (r_val),
        .o_stat  (w_st_b)
    );

    assign w_st_sel   = r_sel ? w_st_b : w_st_a;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // heads are the cell-0 entries of the rotating chains
    assign w_ha     = (r_ca < w_st_a.count);
    assign w_hb     = (r_cb < w_st_b.count);
    assign w_take_a = !w_hb || (w_ha && (w_st_a.head_key < w_st_b.head_key));
    assign w_take_b = !w_take_a && (!w_ha || (w_st_b.head_key < w_st_a.head_key));
    assign w_both   = !w_take_a && !w_take_b;
    assign w_done   = r_sym ? !(w_ha || w_hb) : !(w_ha && w_hb);
    assign w_row_gen = r_sym ? !w_both : w_both;

    always_comb begin
        w_row         = '0;
        w_row.status  = ST_OK;
        if (w_take_a) begin
            w_row.row_key = w_st_a.head_key;
            w_row.value_a = smj_ext(w_st_a.head_val);
            w_row.has_a   = 1'b1;
        end else if (w_take_b) begin
            w_row.row_key = w_st_b.head_key;
            w_row.value_b = smj_ext(w_st_b.head_val);
            w_row.has_b   = 1'b1;
        end else begin
            w_row.row_key = w_st_a.head_key;
            w_row.value_a = smj_ext(w_st_a.head_val);
            w_row.value_b = smj_ext(w_st_b.head_val);
            w_row.has_a   = 1'b1;
            w_row.has_b   = 1'b1;
        end
    end

    // insert answer: duplicate wins over full
    always_comb begin
        w_ins_res         = '0;
        w_ins_res.row_key = r_key;
        w_ins_res.last    = 1'b1;
        if (w_st_sel.dup) begin
            w_ins_res.status = ST_DUP;
        end else if (w_st_sel.full) begin
            w_ins_res.status = ST_FULL;
        end else begin
            w_ins_res.status = ST_OK;
        end
    end

    always_comb begin
        w_empty        = '0;
        w_empty.status = ST_EMPTY;
        w_empty.last   = 1'b1;
    end

    always_comb begin
        n_state      = r_state;
        n_sym        = r_sym;
        n_sel        = r_sel;
        n_key        = r_key;
        n_val        = r_val;
        n_ca         = r_ca;
        n_cb         = r_cb;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_ctl_a      = '{op: CELL_HOLD, clear: 1'b0};
        w_ctl_b      = '{op: CELL_HOLD, clear: 1'b0};

        // output transaction taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sel = i_in.table_sel;
                    n_key = i_in.key;
                    n_val = i_in.row_value[SMJ_VALUE_BITS-1:0];
                    n_sym = (i_in.req_type == REQ_SYMDIFF);
                    case (i_in.req_type)
                        REQ_INSERT: begin
                            n_state = S_CMP;
                        end
                        REQ_TRUNCATE: begin
                            if (i_in.table_sel) begin
                                w_ctl_b.clear = 1'b1;
                            end else begin
                                w_ctl_a.clear = 1'b1;
                            end
                        end
                        default: begin
                            n_ca         = '0;
                            n_cb         = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_WALK;
                        end
                    endcase
                end
            end
            S_CMP: begin
                // every cell compares against the new key
                if (r_sel) begin
                    w_ctl_b.op = CELL_CMP;
                end else begin
                    w_ctl_a.op = CELL_CMP;
                end
                n_state = S_INS;
            end
            S_INS: begin
                if (w_out_free) begin
                    if (r_sel) begin
                        w_ctl_b.op = CELL_INSERT;
                    end else begin
                        w_ctl_a.op = CELL_INSERT;
                    end
                    n_out       = w_ins_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_WALK: begin
                if (w_done) begin
                    n_state = S_FLUSH;
                end else if (!(w_row_gen && r_pend_valid && !w_out_free)) begin
                    if (w_row_gen) begin
                        // push the held row out, hold the new one
                        if (r_pend_valid) begin
                            n_out       = r_pend;
                            n_out_valid = 1'b1;
                        end
                        n_pend       = w_row;
                        n_pend_valid = 1'b1;
                    end
                    if (w_take_a || w_both) begin
                        w_ctl_a.op = CELL_ROTATE;
                        n_ca       = r_ca + 1'b1;
                    end
                    if (w_take_b || w_both) begin
                        w_ctl_b.op = CELL_ROTATE;
                        n_cb       = r_cb + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    if (r_pend_valid) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = w_empty;
                    end
                    n_out_valid  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_RESTORE;
                end
            end
            S_RESTORE: begin
                // turn each chain back to its home position
                if (r_ca == SMJ_CNT_W'(SMJ_DEPTH) && r_cb == SMJ_CNT_W'(SMJ_DEPTH)) begin
                    n_state = S_IDLE;
                end
                if (r_ca != SMJ_CNT_W'(SMJ_DEPTH)) begin
                    w_ctl_a.op = CELL_ROTATE;
                    n_ca       = r_ca + 1'b1;
                end
                if (r_cb != SMJ_CNT_W'(SMJ_DEPTH)) begin
                    w_ctl_b.op = CELL_ROTATE;
                    n_cb       = r_cb + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        // payload and walk counters
        r_sym  <= n_sym;
        r_sel  <= n_sel;
        r_key  <= n_key;
        r_val  <= n_val;
        r_ca   <= n_ca;
        r_cb   <= n_cb;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
